// ----- design/abe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abe_pkg
// Shared types, codes and helpers of the alpha blit engine.
// ----------------------------------------------------------------------------
package abe_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int PIX_W      = 32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 4'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       clipped;
    } t_out_rsp;

    // floor(v / 255), exact for v < 65280 (the 8-bit result of the exact quotient)
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- design/abe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abe_ram
// Simple dual-port RAM, one write port, one registered read port (read-first).
// ----------------------------------------------------------------------------
module abe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/alpha_blit_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_blit_engine
// RGBA8 frame store with pixel write, read and source-over alpha blend.
// ----------------------------------------------------------------------------
// One request is taken every clock unless i_out_ready back-pressure stalls the
// pipeline; a request passes the input register, then address multiply and RAM
// read, blend multiply, and divide with write back into the output register.
// The rate is set by the single frame RAM, read once and written once per
// request; writes still in flight are forwarded to younger blends and reads of
// the same pixel. The frame RAM holds MAX_DIM*MAX_DIM pixels and is not cleared
// at reset: a pixel must be written before it is read or blended. Configuration
// is taken in any cycle and must only change while no request is in flight.
module alpha_blit_engine #(
    parameter int MAX_DIM = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  abe_pkg::t_in_req                   i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output abe_pkg::t_out_rsp                  o_out_rsp,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [abe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [abe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [15:0] r_offset_x;
    logic [15:0] r_offset_y;
    logic [8:0]  r_dest_width;
    logic [8:0]  r_dest_height;
    logic [8:0]  w_eff;
    logic [8:0]  h_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x    <= 16'd0;
            r_offset_y    <= 16'd0;
            r_dest_width  <= 9'd256;
            r_dest_height <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                abe_pkg::CFG_OFFSET_X:    r_offset_x    <= i_cfg_data;
                abe_pkg::CFG_OFFSET_Y:    r_offset_y    <= i_cfg_data;
                abe_pkg::CFG_DEST_WIDTH:  r_dest_width  <= i_cfg_data[8:0];
                abe_pkg::CFG_DEST_HEIGHT: r_dest_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (32'(r_dest_width) > MAX_DIM) ? 9'(MAX_DIM) : r_dest_width;
    assign h_eff = (32'(r_dest_height) > MAX_DIM) ? 9'(MAX_DIM) : r_dest_height;

    // stage enables
    logic en1, en2, en3, en_out;
    logic r_v1, r_v2, r_v3, r_out_valid;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en3        = !r_v3 || en_out;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    // stage 1: target coordinates and clipping
    logic               is_blend;
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic               clip_in;

    assign is_blend = (i_in_req.opcode == abe_pkg::OP_BLEND);
    assign xs = $signed({9'd0, i_in_req.pos_x})
              + (is_blend ? $signed({r_offset_x[15], r_offset_x}) : 17'sd0);
    assign ys = $signed({9'd0, i_in_req.pos_y})
              + (is_blend ? $signed({r_offset_y[15], r_offset_y}) : 17'sd0);
    assign clip_in = (i_in_req.opcode == abe_pkg::OP_NONE) || xs[16] || ys[16]
                   || (xs[15:0] >= {7'd0, w_eff}) || (ys[15:0] >= {7'd0, h_eff});

    logic [1:0]              r_op1;
    logic                    r_clip1;
    logic [8:0]              r_x1;
    logic [8:0]              r_y1;
    logic [abe_pkg::PIX_W-1:0] r_pix1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_op1   <= i_in_req.opcode;
            r_clip1 <= clip_in;
            r_x1    <= xs[8:0];
            r_y1    <= ys[8:0];
            r_pix1  <= {i_in_req.alpha_in, i_in_req.blue_in,
                        i_in_req.green_in, i_in_req.red_in};
        end
    end

    // stage 2: linear address, frame RAM read
    logic [17:0]               lin_addr;
    logic [AW-1:0]             rd_addr;
    logic [abe_pkg::PIX_W-1:0] ram_rdata;
    logic                      ram_we;
    logic [AW-1:0]             r_addr3;
    logic [abe_pkg::PIX_W-1:0] px3;

    assign lin_addr = ({9'd0, r_y1} * {9'd0, w_eff}) + {9'd0, r_x1};
    assign rd_addr  = AW'(lin_addr);

    abe_ram #(
        .WIDTH (abe_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr3),
        .i_wdata (px3),
        .i_re    (en2),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    logic [1:0]                r_op2;
    logic                      r_clip2;
    logic [AW-1:0]             r_addr2;
    logic [abe_pkg::PIX_W-1:0] r_pix2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_op2   <= r_op1;
            r_clip2 <= r_clip1;
            r_addr2 <= rd_addr;
            r_pix2  <= r_pix1;
        end
    end

    // stage 2 compute: forwarding and blend products
    logic                      r_wr3;
    logic                      r_lw_valid;
    logic [AW-1:0]             r_lw_addr;
    logic [abe_pkg::PIX_W-1:0] r_lw_data;
    logic [abe_pkg::PIX_W-1:0] dst;
    logic [abe_pkg::PIX_W-1:0] pass2;
    logic                      wr2;
    logic [7:0]                alpha2;
    logic [7:0]                inv2;
    logic [3:0][15:0]          sum2;

    always_comb begin
        if (r_v3 && r_wr3 && (r_addr3 == r_addr2)) begin
            dst = px3;
        end else if (r_lw_valid && (r_lw_addr == r_addr2)) begin
            dst = r_lw_data;
        end else begin
            dst = ram_rdata;
        end
    end

    assign alpha2 = r_pix2[31:24];
    assign inv2   = ~alpha2;
    assign wr2    = !r_clip2 && ((r_op2 == abe_pkg::OP_WRITE) || (r_op2 == abe_pkg::OP_BLEND));
    assign pass2  = (r_op2 == abe_pkg::OP_WRITE) ? r_pix2 : dst;

    assign sum2[0] = ({8'd0, r_pix2[7:0]} * {8'd0, alpha2})
                   + ({8'd0, dst[7:0]} * {8'd0, inv2});
    assign sum2[1] = ({8'd0, r_pix2[15:8]} * {8'd0, alpha2})
                   + ({8'd0, dst[15:8]} * {8'd0, inv2});
    assign sum2[2] = ({8'd0, r_pix2[23:16]} * {8'd0, alpha2})
                   + ({8'd0, dst[23:16]} * {8'd0, inv2});
    assign sum2[3] = ({8'd0, 8'hFF} * {8'd0, alpha2})
                   + ({8'd0, dst[31:24]} * {8'd0, inv2});

    // stage 3: divide, write back
    logic                      r_blend3;
    logic                      r_clip3;
    logic [3:0][15:0]          r_sum3;
    logic [abe_pkg::PIX_W-1:0] r_pass3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_blend3 <= (r_op2 == abe_pkg::OP_BLEND);
            r_clip3  <= r_clip2;
            r_wr3    <= wr2;
            r_addr3  <= r_addr2;
            r_sum3   <= sum2;
            r_pass3  <= pass2;
        end
    end

    assign px3 = r_blend3 ? {abe_pkg::div255(r_sum3[3]), abe_pkg::div255(r_sum3[2]),
                             abe_pkg::div255(r_sum3[1]), abe_pkg::div255(r_sum3[0])}
                          : r_pass3;
    assign ram_we = en_out && r_v3 && r_wr3;

    // last write, covers a read issued on the same edge as the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (ram_we) begin
            r_lw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_lw_addr <= r_addr3;
            r_lw_data <= px3;
        end
    end

    // output register
    logic [abe_pkg::PIX_W-1:0] r_out_px;
    logic                      r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v3) begin
            r_out_px   <= r_clip3 ? '0 : px3;
            r_out_clip <= r_clip3;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_rsp.red_out   = r_out_px[7:0];
    assign o_out_rsp.green_out = r_out_px[15:8];
    assign o_out_rsp.blue_out  = r_out_px[23:16];
    assign o_out_rsp.alpha_out = r_out_px[31:24];
    assign o_out_rsp.clipped   = r_out_clip;

endmodule
`default_nettype wire

// ----- design/abe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abe_checker
// Port-level checks of the alpha blit engine, bound to the top level.
// ----------------------------------------------------------------------------
module abe_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  abe_pkg::t_in_req               i_in_req,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  abe_pkg::t_out_rsp              o_out_rsp,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [abe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // a clipped result carries a zero pixel
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.clipped |->
            (o_out_rsp.red_out == 8'd0) && (o_out_rsp.green_out == 8'd0) &&
            (o_out_rsp.blue_out == 8'd0) && (o_out_rsp.alpha_out == 8'd0))
        else $error("clipped result with nonzero pixel");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty output register never blocks the request side for long
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(!o_out_valid) && $past(!o_out_valid, 2) &&
        $past(!o_out_valid, 3) && $past(i_rst_n, 3) |-> o_in_ready)
        else $error("request side stalled with empty pipeline");

endmodule

bind alpha_blit_engine abe_checker u_abe_checker (.*);
`default_nettype wire
